>>> rtl/tsrr_pkg.sv
// Shared types and constants for the task slot round-robin scheduler.
// No dependencies; imported by the interfaces, the scan unit and the top level.
package tsrr_pkg;

    localparam int REQ_W     = 2;
    localparam int SLOT_ID_W = 4;
    localparam int STACK_W   = 32;
    localparam int COUNT_W   = 5;

    // request codes; the fourth code is unknown and is rejected
    localparam logic [REQ_W-1:0] REQ_CREATE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DESTROY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SWITCH  = 2'd2;

    // sequencer to scan unit
    typedef struct packed {
        logic start;
        logic want;     // used-bit value the scan looks for
    } t_scan_ctl;

    // scan unit to sequencer
    typedef struct packed {
        logic done;
        logic found;
    } t_scan_sts;

endpackage

>>> rtl/tsrr_if.sv
// Valid/ready channel interfaces for scheduler requests and responses.
// Depends on tsrr_pkg for field widths.
interface tsrr_req_if;
    import tsrr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [STACK_W-1:0]   stack_ptr;
    modport source (output valid, req_type, slot_id, stack_ptr, input ready);
    modport sink   (input valid, req_type, slot_id, stack_ptr, output ready);
endinterface

interface tsrr_rsp_if;
    import tsrr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [SLOT_ID_W-1:0] result_slot;
    logic                 ok;
    logic [STACK_W-1:0]   stack_out;
    logic                 switched;
    logic [COUNT_W-1:0]   live_count;
    modport source (output valid, result_slot, ok, stack_out, switched, live_count,
                    input ready);
    modport sink   (input valid, result_slot, ok, stack_out, switched, live_count,
                    output ready);
endinterface

>>> rtl/tsrr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tsrr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tsrr_scan.sv
// Slot scan unit: steps one slot per cycle looking for a given used-bit value.
// Depends on tsrr_pkg for the control and status structs.
module tsrr_scan #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [NUM_SLOTS-1:0]             i_used,
    input  tsrr_pkg::t_scan_ctl              i_ctl,
    input  logic [$clog2(NUM_SLOTS):0]       i_from,
    output tsrr_pkg::t_scan_sts              o_sts,
    output logic [$clog2(NUM_SLOTS)-1:0]     o_idx
);
    import tsrr_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam logic [SW:0] LIMIT = (SW+1)'(NUM_SLOTS);

    logic          r_busy, n_busy;
    logic          r_want, n_want;
    logic [SW:0]   r_idx,  n_idx;
    logic          w_past_end;
    logic          w_match;

    // compare the current slot against the wanted value
    assign w_past_end = (r_idx >= LIMIT);
    assign w_match    = (i_used[r_idx[SW-1:0]] == r_want);

    assign o_sts.done  = r_busy && (w_past_end || w_match);
    assign o_sts.found = r_busy && !w_past_end && w_match;
    assign o_idx       = r_idx[SW-1:0];

    // load on start, advance until a hit or the end of the table
    always_comb begin
        n_busy = r_busy;
        n_want = r_want;
        n_idx  = r_idx;
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_want = i_ctl.want;
            n_idx  = i_from;
        end else if (r_busy) begin
            if (w_past_end || w_match) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + (SW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_want <= n_want;
        r_idx  <= n_idx;
    end

endmodule

>>> rtl/task_slot_round_robin_scheduler_unit.sv
// Top level of the task slot round-robin scheduler: sequencer, slot table, outputs.
// Depends on tsrr_pkg, tsrr_if, tsrr_ram and tsrr_scan.
//
//   channel  | dir | handshake          | word
//   ---------+-----+--------------------+------------------------------------------
//   i_req    | in  | valid/ready        | req_type, slot_id, stack_ptr
//   o_rsp    | out | valid/ready        | result_slot, ok, stack_out, switched,
//            |     |                    | live_count
//
// Destroy and unknown requests pass from dispatch straight to finish.
// Create scans from slot 0 for the lowest free slot and fails when the table is full.
// Switch scans the slots above the running one and picks the first used one, or
// slot 0 on a wrap, then reads the stack memory in the read state when the chosen
// slot changes.
// The scan unit tests one slot per cycle.
// Reset is synchronous; slot 0 is used and running afterward, no sweep is needed.
// A new request is taken while a response waits; it then holds before output.
module task_slot_round_robin_scheduler_unit #(
    parameter int NUM_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tsrr_req_if.sink          i_req,
    tsrr_rsp_if.source        o_rsp
);
    import tsrr_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_SCAN     = 5'b00100,
        S_READ     = 5'b01000,
        S_FINISH   = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [NUM_SLOTS-1:0]  r_used,  n_used;
    logic [SW-1:0]         r_run,   n_run;
    logic [COUNT_W-1:0]    r_total, n_total;

    logic [REQ_W-1:0]      r_req,   n_req;
    logic [SLOT_ID_W-1:0]  r_sid,   n_sid;
    logic [STACK_W-1:0]    r_stk,   n_stk;

    logic [SLOT_ID_W-1:0]  r_res_slot,   n_res_slot;
    logic                  r_res_ok,     n_res_ok;
    logic [STACK_W-1:0]    r_res_stack,  n_res_stack;
    logic                  r_res_sw,     n_res_sw;

    logic                  r_out_valid,  n_out_valid;
    logic [SLOT_ID_W-1:0]  r_out_slot;
    logic                  r_out_ok;
    logic [STACK_W-1:0]    r_out_stack;
    logic                  r_out_sw;
    logic [COUNT_W-1:0]    r_out_total;

    t_scan_ctl             w_scan_ctl;
    t_scan_sts             w_scan_sts;
    logic [SW:0]           w_scan_from;
    logic [SW-1:0]         w_scan_idx;

    logic                  w_ram_we;
    logic [SW-1:0]         w_ram_waddr;
    logic [STACK_W-1:0]    w_ram_wdata;
    logic [SW-1:0]         w_ram_raddr;
    logic [STACK_W-1:0]    w_ram_rdata;

    logic                  w_sid_ok;
    logic [SW-1:0]         w_sid_idx;
    logic [SW-1:0]         w_nxt;
    logic                  w_out_load;

    // saved stack pointers per slot
    tsrr_ram #(
        .WIDTH (STACK_W),
        .DEPTH (NUM_SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // shared slot scan
    tsrr_scan #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_used  (r_used),
        .i_ctl   (w_scan_ctl),
        .i_from  (w_scan_from),
        .o_sts   (w_scan_sts),
        .o_idx   (w_scan_idx)
    );

    // destroy target in range, and the next slot to run after a scan
    assign w_sid_ok  = (int'(r_sid) < NUM_SLOTS);
    assign w_sid_idx = SW'(r_sid);
    assign w_nxt     = w_scan_sts.found ? w_scan_idx : '0;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_out_load  = (r_state == S_FINISH) && (!r_out_valid || o_rsp.ready);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_run       = r_run;
        n_total     = r_total;
        n_req       = r_req;
        n_sid       = r_sid;
        n_stk       = r_stk;
        n_res_slot  = r_res_slot;
        n_res_ok    = r_res_ok;
        n_res_stack = r_res_stack;
        n_res_sw    = r_res_sw;
        w_scan_ctl  = '0;
        w_scan_from = '0;
        w_ram_we    = 1'b0;
        w_ram_waddr = '0;
        w_ram_wdata = '0;
        w_ram_raddr = '0;
        case (r_state)
            S_IDLE: begin
                // latch the request word
                if (i_req.valid) begin
                    n_req   = i_req.req_type;
                    n_sid   = i_req.slot_id;
                    n_stk   = i_req.stack_ptr;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_slot  = '0;
                n_res_ok    = 1'b0;
                n_res_stack = '0;
                n_res_sw    = 1'b0;
                case (r_req)
                    REQ_CREATE: begin
                        // look for the lowest free slot
                        w_scan_ctl.start = 1'b1;
                        w_scan_ctl.want  = 1'b0;
                        n_state          = S_SCAN;
                    end
                    REQ_DESTROY: begin
                        // free a used slot, drop a request for a free one
                        n_state = S_FINISH;
                        if (w_sid_ok && r_used[w_sid_idx]) begin
                            n_used[w_sid_idx] = 1'b0;
                            w_ram_we          = 1'b1;
                            w_ram_waddr       = w_sid_idx;
                            if (r_total != '0) begin
                                n_total = r_total - COUNT_W'(1);
                            end
                            n_res_ok = 1'b1;
                        end
                    end
                    REQ_SWITCH: begin
                        // save the running stack, scan above the running slot
                        w_ram_we         = 1'b1;
                        w_ram_waddr      = r_run;
                        w_ram_wdata      = r_stk;
                        w_scan_ctl.start = 1'b1;
                        w_scan_ctl.want  = 1'b1;
                        w_scan_from      = {1'b0, r_run} + (SW+1)'(1);
                        n_state          = S_SCAN;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                if (w_scan_sts.done) begin
                    if (r_req == REQ_CREATE) begin
                        // claim the free slot and store its stack
                        n_state = S_FINISH;
                        if (w_scan_sts.found) begin
                            n_used[w_scan_idx] = 1'b1;
                            w_ram_we           = 1'b1;
                            w_ram_waddr        = w_scan_idx;
                            w_ram_wdata        = r_stk;
                            n_total            = r_total + COUNT_W'(1);
                            n_res_slot         = SLOT_ID_W'(w_scan_idx);
                            n_res_ok           = 1'b1;
                        end
                    end else begin
                        // hand over to the next slot, bypass the stack on a self pick
                        n_run      = w_nxt;
                        n_res_slot = SLOT_ID_W'(w_nxt);
                        n_res_ok   = 1'b1;
                        n_res_sw   = (w_nxt != r_run);
                        if (w_nxt == r_run) begin
                            n_res_stack = r_stk;
                            n_state     = S_FINISH;
                        end else begin
                            w_ram_raddr = w_nxt;
                            n_state     = S_READ;
                        end
                    end
                end
            end
            S_READ: begin
                n_res_stack = w_ram_rdata;
                n_state     = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register valid: load from the result, clear when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= {{(NUM_SLOTS-1){1'b0}}, 1'b1};
            r_run       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_run       <= n_run;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_sid       <= n_sid;
        r_stk       <= n_stk;
        r_res_slot  <= n_res_slot;
        r_res_ok    <= n_res_ok;
        r_res_stack <= n_res_stack;
        r_res_sw    <= n_res_sw;
        if (w_out_load) begin
            r_out_slot  <= r_res_slot;
            r_out_ok    <= r_res_ok;
            r_out_stack <= r_res_stack;
            r_out_sw    <= r_res_sw;
            r_out_total <= r_total;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_slot = r_out_slot;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.stack_out   = r_out_stack;
    assign o_rsp.switched    = r_out_sw;
    assign o_rsp.live_count  = r_out_total;

`ifndef SYNTH
    // scan results only arrive while the sequencer waits for them
    a_scan_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_sts.done |-> (r_state == S_SCAN))
        else $error("scan finished outside the scan state");

    // a successful create leaves its slot marked used
    a_create_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_scan_sts.done && w_scan_sts.found && r_req == REQ_CREATE)
        |=> r_used[$past(w_scan_idx)])
        else $error("created slot not marked used");

    // a response appears only after the finish state
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("response raised outside the finish state");
`endif

endmodule
